@@ rtl/core/anb_pkg.sv @@
// ----------------------------------------------------------------------------
// anb_pkg
// Shared types and constants for the Annex B NAL unit splitter.
// ----------------------------------------------------------------------------
package anb_pkg;

    // Zero-run counter saturates here
    localparam logic [7:0] ZERO_RUN_MAX = 8'd255;

    // Result queue depth and derived widths
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Byte codes and unit types
    localparam logic [7:0] BYTE_ZERO  = 8'h00;
    localparam logic [7:0] BYTE_ONE   = 8'h01;
    localparam logic [7:0] TYPE_MASK  = 8'h1f;
    localparam logic [4:0] NAL_IDR    = 5'd5;
    localparam logic [4:0] NAL_SPS    = 5'd7;
    localparam logic [4:0] NAL_PPS    = 5'd8;

    // Bit positions in the seen-flags register
    localparam int FLAG_IDR = 0;
    localparam int FLAG_SPS = 1;
    localparam int FLAG_PPS = 2;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       last_in_packet;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [7:0] zeros_before;
        logic       byte_valid;
        logic       first_of_unit;
        logic       last_of_unit;
        logic [4:0] unit_type;
        logic       end_of_packet;
        logic       idr_seen;
        logic       sps_seen;
        logic       pps_seen;
    } t_out_item;

endpackage

@@ rtl/core/annexb_nal_splitter.sv @@
// ----------------------------------------------------------------------------
// annexb_nal_splitter
// Splits an H.264 Annex B byte stream into NAL unit payload bytes.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Valid       | Stall       | Payload
//  --------+-----------+-------------+-------------+---------------------------
//  in      | input     | i_in_valid  | o_in_stall  | i_in_data  (t_in_item)
//  out     | output    | o_out_valid | i_out_stall | o_out_data (t_out_item)
//
//  One input byte is taken every cycle while o_in_stall is low. The parse
//  logic runs in the cycle of acceptance and writes its results into a
//  four-entry queue feeding the output. A byte yields zero, one or (only at
//  packet end) two results, so the input stalls whenever fewer than two queue
//  entries are free. Reset is synchronous and active low and returns the
//  parser to "before the first start code" with an empty queue.
//
module annexb_nal_splitter
    import anb_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_data
);

    // ------------------------------------------------------------------
    // Parser state
    // ------------------------------------------------------------------
    logic [7:0] r_zero_run,     n_zero_run;
    logic       r_inside_unit,  n_inside_unit;
    logic       r_held_valid,   n_held_valid;
    logic [7:0] r_held_byte,    n_held_byte;
    logic [7:0] r_held_zeros,   n_held_zeros;
    logic       r_held_first,   n_held_first;
    logic       r_expect_first, n_expect_first;
    logic [4:0] r_current_type, n_current_type;
    logic [2:0] r_type_flags,   n_type_flags;

    // ------------------------------------------------------------------
    // Result queue
    // ------------------------------------------------------------------
    t_out_item           r_queue [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0]   r_count,  n_count;

    logic       in_fire;
    logic       out_fire;
    logic       is_start;
    logic [4:0] new_type;

    // Up to two results per byte: the closed held byte, then the packet end
    t_out_item  res_held;
    logic       res_held_v;
    t_out_item  res_eop;
    logic       res_eop_v;
    t_out_item  push0;
    t_out_item  push1;
    logic [1:0] push_cnt;

    // Stall while a packet end could overflow the queue
    assign o_in_stall  = (r_count > QCNT_W'(QUEUE_DEPTH - 2));
    assign in_fire     = i_in_valid && !o_in_stall;
    assign o_out_valid = (r_count != '0);
    assign o_out_data  = r_queue[r_rd_ptr];
    assign out_fire    = o_out_valid && !i_out_stall;

    assign is_start = (i_in_data.in_byte == BYTE_ONE) && (r_zero_run >= 8'd2);
    assign new_type = (r_zero_run != '0) ? 5'd0 : 5'(i_in_data.in_byte & TYPE_MASK);

    // ------------------------------------------------------------------
    // Parse one byte
    // ------------------------------------------------------------------
    always_comb begin
        n_zero_run     = r_zero_run;
        n_inside_unit  = r_inside_unit;
        n_held_valid   = r_held_valid;
        n_held_byte    = r_held_byte;
        n_held_zeros   = r_held_zeros;
        n_held_first   = r_held_first;
        n_expect_first = r_expect_first;
        n_current_type = r_current_type;
        n_type_flags   = r_type_flags;

        res_held               = '0;
        res_held.out_byte      = r_held_byte;
        res_held.zeros_before  = r_held_zeros;
        res_held.byte_valid    = 1'b1;
        res_held.first_of_unit = r_held_first;
        res_held.unit_type     = r_current_type;
        res_held.idr_seen      = r_type_flags[FLAG_IDR];
        res_held.sps_seen      = r_type_flags[FLAG_SPS];
        res_held.pps_seen      = r_type_flags[FLAG_PPS];
        res_held_v             = 1'b0;

        if (i_in_data.in_byte == BYTE_ZERO) begin
            // Fold the zero into the run count
            if (r_zero_run < ZERO_RUN_MAX) begin
                n_zero_run = r_zero_run + 8'd1;
            end
        end else if (is_start) begin
            // Close the held unit, open a new one
            res_held.last_of_unit = 1'b1;
            res_held_v            = r_held_valid;
            n_held_valid          = 1'b0;
            n_inside_unit         = 1'b1;
            n_expect_first        = 1'b1;
            n_zero_run            = '0;
        end else begin
            if (r_inside_unit) begin
                res_held_v = r_held_valid;
                if (r_expect_first) begin
                    n_current_type = new_type;
                    if (new_type == NAL_IDR) n_type_flags[FLAG_IDR] = 1'b1;
                    if (new_type == NAL_SPS) n_type_flags[FLAG_SPS] = 1'b1;
                    if (new_type == NAL_PPS) n_type_flags[FLAG_PPS] = 1'b1;
                    n_expect_first = 1'b0;
                    n_held_first   = 1'b1;
                end else begin
                    n_held_first = 1'b0;
                end
                n_held_byte  = i_in_data.in_byte;
                n_held_zeros = r_zero_run;
                n_held_valid = 1'b1;
            end
            n_zero_run = '0;
        end

        // Packet end: flush the held byte or emit a summary-only transaction
        res_eop               = '0;
        res_eop.end_of_packet = 1'b1;
        res_eop.idr_seen      = n_type_flags[FLAG_IDR];
        res_eop.sps_seen      = n_type_flags[FLAG_SPS];
        res_eop.pps_seen      = n_type_flags[FLAG_PPS];
        if (n_held_valid) begin
            res_eop.out_byte      = n_held_byte;
            res_eop.zeros_before  = n_held_zeros;
            res_eop.byte_valid    = 1'b1;
            res_eop.first_of_unit = n_held_first;
            res_eop.last_of_unit  = 1'b1;
            res_eop.unit_type     = n_current_type;
        end
        res_eop_v = i_in_data.last_in_packet;

        if (i_in_data.last_in_packet) begin
            // Drop all parser state back to reset
            n_zero_run     = '0;
            n_inside_unit  = 1'b0;
            n_held_valid   = 1'b0;
            n_held_byte    = '0;
            n_held_zeros   = '0;
            n_held_first   = 1'b0;
            n_expect_first = 1'b0;
            n_current_type = '0;
            n_type_flags   = '0;
        end
    end

    // ------------------------------------------------------------------
    // Pack results into the queue in order
    // ------------------------------------------------------------------
    always_comb begin
        push0    = res_eop;
        push1    = res_eop;
        push_cnt = 2'd0;
        if (in_fire) begin
            if (res_held_v) begin
                push0    = res_held;
                push_cnt = res_eop_v ? 2'd2 : 2'd1;
            end else begin
                push_cnt = res_eop_v ? 2'd1 : 2'd0;
            end
        end
        n_wr_ptr = r_wr_ptr + QPTR_W'(push_cnt);
        n_rd_ptr = r_rd_ptr + QPTR_W'(out_fire);
        n_count  = r_count + QCNT_W'(push_cnt) - QCNT_W'(out_fire);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero_run     <= '0;
            r_inside_unit  <= 1'b0;
            r_held_valid   <= 1'b0;
            r_held_byte    <= '0;
            r_held_zeros   <= '0;
            r_held_first   <= 1'b0;
            r_expect_first <= 1'b0;
            r_current_type <= '0;
            r_type_flags   <= '0;
            r_wr_ptr       <= '0;
            r_rd_ptr       <= '0;
            r_count        <= '0;
        end else begin
            // Advance parser state only on an accepted transaction
            if (in_fire) begin
                r_zero_run     <= n_zero_run;
                r_inside_unit  <= n_inside_unit;
                r_held_valid   <= n_held_valid;
                r_held_byte    <= n_held_byte;
                r_held_zeros   <= n_held_zeros;
                r_held_first   <= n_held_first;
                r_expect_first <= n_expect_first;
                r_current_type <= n_current_type;
                r_type_flags   <= n_type_flags;
            end
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Queue storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (push_cnt != 2'd0) begin
            r_queue[r_wr_ptr] <= push0;
        end
        if (push_cnt == 2'd2) begin
            r_queue[r_wr_ptr + QPTR_W'(1)] <= push1;
        end
    end

endmodule

@@ rtl/core/anb_checker.sv @@
// ----------------------------------------------------------------------------
// anb_checker
// Port-level checks for the Annex B NAL unit splitter.
// ----------------------------------------------------------------------------
module anb_checker
    import anb_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input t_in_item  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_item o_out_data
);

    // Input only backs up when results are waiting
    a_stall_needs_backlog: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with an empty output");

    // A summary-only transaction exists only as the packet end
    a_summary_is_eop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.byte_valid) |-> o_out_data.end_of_packet)
        else $error("summary-only transaction without end of packet");

    // A byte carrying the packet end also closes its unit
    a_eop_closes_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.byte_valid && o_out_data.end_of_packet)
            |-> o_out_data.last_of_unit)
        else $error("packet end on a byte not marked last of unit");

    // Stalled output transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled output transaction changed");

    // Stalled input transaction holds
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_stall) |=> (i_in_valid && $stable(i_in_data)))
        else $error("stalled input transaction changed");

endmodule

bind annexb_nal_splitter anb_checker u_anb_checker (.*);
